>>> sv/sv39pt_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sv39 page table package
// Shared sizes, codes and types of the Sv39 map and translate unit.
// ----------------------------------------------------------------------------
package sv39pt_pkg;

   // Table pool geometry.
   localparam int POOL_PAGES       = 8;
   localparam int ENTRIES_PER_PAGE = 512;
   localparam int IDX_W            = 9;
   localparam int PAGE_W           = (POOL_PAGES > 1) ? $clog2(POOL_PAGES) : 1;
   localparam int ADDR_W           = PAGE_W + IDX_W;
   localparam int MEM_DEPTH        = POOL_PAGES * ENTRIES_PER_PAGE;
   localparam int NFP_W            = 7;

   // Word and field widths.
   localparam int PA_W    = 56;
   localparam int PPN_W   = 44;
   localparam int VA_W    = 64;
   localparam int CNT_W   = 16;
   localparam int PERM_W  = 8;
   localparam int ENTRY_W = 64;
   localparam int REQ_W   = 144;
   localparam int RSP_W   = 64;

   // Entry flag bit positions.
   localparam int FLAG_V = 0;
   localparam int FLAG_U = 4;

   typedef enum logic [2:0] {
      STAT_OK    = 3'd0,
      STAT_POOL  = 3'd1,
      STAT_ALIGN = 3'd2,
      STAT_ZERO  = 3'd3,
      STAT_REMAP = 3'd4,
      STAT_RANGE = 3'd5
   } status_type;

   typedef enum logic {
      CMD_MAP       = 1'b0,
      CMD_TRANSLATE = 1'b1
   } command_type;

   typedef enum logic [3:0] {
      ST_INIT,
      ST_IDLE,
      ST_CHECK,
      ST_PAGE,
      ST_RD,
      ST_EVAL,
      ST_CLEAR,
      ST_LINK,
      ST_DONE
   } state_type;

   // Decoded pointer entry: pool page it names and whether it lies in the pool.
   typedef struct packed {
      logic              in_pool;
      logic [PAGE_W-1:0] page;
   } ptr_info_type;

endpackage

>>> sv/sv39pt_table_mem.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sv39 table store
// Pool of table pages, one write port and one registered read port.
// ----------------------------------------------------------------------------
module sv39pt_table_mem (
   input  logic                                 clock,
   input  logic                                 wr_en,
   input  logic [sv39pt_pkg::ADDR_W-1:0]        wr_addr,
   input  logic [sv39pt_pkg::ENTRY_W-1:0]       wr_data,
   input  logic [sv39pt_pkg::ADDR_W-1:0]        rd_addr,
   output logic [sv39pt_pkg::ENTRY_W-1:0]       rd_data
);

   logic [sv39pt_pkg::ENTRY_W-1:0] mem [sv39pt_pkg::MEM_DEPTH];
   logic [sv39pt_pkg::ENTRY_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

>>> sv/sv39pt_entry_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sv39 entry unit
// Decodes a table entry against the pool origin and builds pointer and leaf
// entries. One subtractor serves every level of the walk.
// ----------------------------------------------------------------------------
module sv39pt_entry_unit (
   input  logic [sv39pt_pkg::ENTRY_W-1:0] entry,
   input  logic [sv39pt_pkg::PPN_W-1:0]   origin_ppn,
   input  logic [sv39pt_pkg::PAGE_W-1:0]  alloc_page,
   input  logic [sv39pt_pkg::PPN_W-1:0]   leaf_ppn,
   input  logic [sv39pt_pkg::PERM_W-1:0]  leaf_perm,
   output sv39pt_pkg::ptr_info_type       ptr_info,
   output logic [sv39pt_pkg::PA_W-1:0]    entry_pa,
   output logic [sv39pt_pkg::ENTRY_W-1:0] link_entry,
   output logic [sv39pt_pkg::ENTRY_W-1:0] leaf_entry
);

   logic [sv39pt_pkg::PPN_W-1:0] entry_ppn;
   logic [sv39pt_pkg::PPN_W-1:0] offset_ppn;
   logic [sv39pt_pkg::PPN_W-1:0] link_ppn;
   logic [sv39pt_pkg::PERM_W-1:0] perm_v;

   always_comb begin
      entry_ppn  = entry[53:10];
      // Page distance from the pool origin, modulo the physical address space.
      offset_ppn = entry_ppn - origin_ppn;
      ptr_info.in_pool = (offset_ppn < sv39pt_pkg::PPN_W'(sv39pt_pkg::POOL_PAGES));
      ptr_info.page    = offset_ppn[sv39pt_pkg::PAGE_W-1:0];
      entry_pa   = {entry_ppn, 12'h000};

      link_ppn   = origin_ppn + sv39pt_pkg::PPN_W'(alloc_page);
      link_entry = {10'h000, link_ppn, 10'h001};

      perm_v     = leaf_perm | sv39pt_pkg::PERM_W'(1);
      leaf_entry = {10'h000, leaf_ppn, 2'b00, perm_v};
   end

endmodule

>>> sv/sv39_page_table_map_and_translate_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sv39 page table map and translate unit
// Keeps a three-level Sv39 table in a pool of table pages, maps runs of pages
// and translates virtual addresses, one word at a time.
// ----------------------------------------------------------------------------
//  Channel  Dir  Contents
//  req_     in   tuser: command; tdata: virt_addr, phys_addr, page_count, perm
//  rsp_     out  tdata: status, result_addr
//  csr_     in   pool_base write
//
// A translate makes three table reads, each through the registered memory read port.
// A map walks the table once per page; each table page taken from the pool is first
// swept clear one entry a cycle. After reset the whole store (POOL_PAGES * 512 entries)
// is cleared before req_tready first rises; csr writes are taken during that pass.
// A finished word waits in the output register while the next request is taken.
// ----------------------------------------------------------------------------
module sv39_page_table_map_and_translate_unit (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   // [63:0] virt_addr, [119:64] phys_addr, [135:120] page_count, [143:136] perm_flags
   input  logic [sv39pt_pkg::REQ_W-1:0]      req_tdata,
   // [0] command
   input  logic [0:0]                        req_tuser,
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   // [2:0] status, [58:3] result_addr, [63:59] zero
   output logic [sv39pt_pkg::RSP_W-1:0]      rsp_tdata,
   input  logic                              csr_we,
   input  logic [sv39pt_pkg::PA_W-1:0]       csr_wdata
);

   sv39pt_pkg::state_type            state_ff, state_in;
   logic [sv39pt_pkg::PA_W-1:0]      pool_base_ff, pool_base_in;
   logic                             cmd_ff, cmd_in;
   logic [sv39pt_pkg::VA_W-1:0]      va_ff, va_in;
   logic [sv39pt_pkg::PPN_W-1:0]     pa_ppn_ff, pa_ppn_in;
   logic [sv39pt_pkg::CNT_W-1:0]     count_ff, count_in;
   logic [sv39pt_pkg::PERM_W-1:0]    perm_ff, perm_in;
   logic [1:0]                       level_ff, level_in;
   logic [sv39pt_pkg::PAGE_W-1:0]    page_ff, page_in;
   logic [sv39pt_pkg::PAGE_W-1:0]    alloc_page_ff, alloc_page_in;
   logic [sv39pt_pkg::NFP_W-1:0]     next_free_ff, next_free_in;
   logic [sv39pt_pkg::ADDR_W-1:0]    clr_addr_ff, clr_addr_in;
   sv39pt_pkg::status_type           stat_ff, stat_in;
   logic [sv39pt_pkg::PA_W-1:0]      res_addr_ff, res_addr_in;
   logic                             rsp_valid_ff, rsp_valid_in;
   sv39pt_pkg::status_type           rsp_status_ff, rsp_status_in;
   logic [sv39pt_pkg::PA_W-1:0]      rsp_addr_ff, rsp_addr_in;

   logic [sv39pt_pkg::IDX_W-1:0]     idx;
   logic [sv39pt_pkg::ADDR_W-1:0]    mem_raddr;
   logic [sv39pt_pkg::ADDR_W-1:0]    mem_waddr;
   logic [sv39pt_pkg::ENTRY_W-1:0]   mem_wdata;
   logic [sv39pt_pkg::ENTRY_W-1:0]   mem_rdata;
   logic                             mem_we;
   sv39pt_pkg::ptr_info_type         ptr_info;
   logic [sv39pt_pkg::PA_W-1:0]      entry_pa;
   logic [sv39pt_pkg::ENTRY_W-1:0]   link_entry;
   logic [sv39pt_pkg::ENTRY_W-1:0]   leaf_entry;

   logic req_fire;
   logic is_map;
   logic bad_align;
   logic bad_range;
   logic pool_full;
   logic slot_free;
   logic init_last;
   logic clr_last;

   assign req_tready = (state_ff == sv39pt_pkg::ST_IDLE);
   assign req_fire   = req_tvalid && req_tready;
   assign is_map     = (cmd_ff == sv39pt_pkg::CMD_MAP);
   assign bad_align  = (va_ff[11:0] != 12'h000);
   assign bad_range  = (va_ff[63:38] != 26'h0);
   assign pool_full  = (next_free_ff >= sv39pt_pkg::NFP_W'(sv39pt_pkg::POOL_PAGES));
   assign slot_free  = !rsp_valid_ff || rsp_tready;
   assign init_last  = (clr_addr_ff == sv39pt_pkg::ADDR_W'(sv39pt_pkg::MEM_DEPTH - 1));
   assign clr_last   = &clr_addr_ff[sv39pt_pkg::IDX_W-1:0];

   always_comb begin
      case (level_ff)
         2'd2:    idx = va_ff[38:30];
         2'd1:    idx = va_ff[29:21];
         default: idx = va_ff[20:12];
      endcase
   end

   assign mem_raddr = {page_ff, idx};

   sv39pt_table_mem u_table_mem (
      .clock   (clock),
      .wr_en   (mem_we),
      .wr_addr (mem_waddr),
      .wr_data (mem_wdata),
      .rd_addr (mem_raddr),
      .rd_data (mem_rdata)
   );

   sv39pt_entry_unit u_entry_unit (
      .entry      (mem_rdata),
      .origin_ppn (pool_base_ff[55:12]),
      .alloc_page (alloc_page_ff),
      .leaf_ppn   (pa_ppn_ff),
      .leaf_perm  (perm_ff),
      .ptr_info   (ptr_info),
      .entry_pa   (entry_pa),
      .link_entry (link_entry),
      .leaf_entry (leaf_entry)
   );

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         sv39pt_pkg::ST_INIT: begin
            if (init_last) state_in = sv39pt_pkg::ST_IDLE;
         end
         sv39pt_pkg::ST_IDLE: begin
            if (req_fire) state_in = sv39pt_pkg::ST_CHECK;
         end
         sv39pt_pkg::ST_CHECK: begin
            if (is_map && (bad_align || (count_ff == '0))) begin
               state_in = sv39pt_pkg::ST_DONE;
            end else begin
               state_in = sv39pt_pkg::ST_PAGE;
            end
         end
         sv39pt_pkg::ST_PAGE: begin
            state_in = bad_range ? sv39pt_pkg::ST_DONE : sv39pt_pkg::ST_RD;
         end
         sv39pt_pkg::ST_RD: begin
            state_in = sv39pt_pkg::ST_EVAL;
         end
         sv39pt_pkg::ST_EVAL: begin
            if (level_ff != 2'd0) begin
               if (mem_rdata[sv39pt_pkg::FLAG_V]) begin
                  state_in = ptr_info.in_pool ? sv39pt_pkg::ST_RD : sv39pt_pkg::ST_DONE;
               end else if (!is_map || pool_full) begin
                  state_in = sv39pt_pkg::ST_DONE;
               end else begin
                  state_in = sv39pt_pkg::ST_CLEAR;
               end
            end else if (!is_map || mem_rdata[sv39pt_pkg::FLAG_V]
                         || (count_ff == sv39pt_pkg::CNT_W'(1))) begin
               state_in = sv39pt_pkg::ST_DONE;
            end else begin
               state_in = sv39pt_pkg::ST_PAGE;
            end
         end
         sv39pt_pkg::ST_CLEAR: begin
            if (clr_last) state_in = sv39pt_pkg::ST_LINK;
         end
         sv39pt_pkg::ST_LINK: begin
            state_in = sv39pt_pkg::ST_RD;
         end
         sv39pt_pkg::ST_DONE: begin
            if (slot_free) state_in = sv39pt_pkg::ST_IDLE;
         end
         default: state_in = sv39pt_pkg::ST_IDLE;
      endcase
   end

   // Datapath and memory port control.
   always_comb begin
      pool_base_in  = csr_we ? csr_wdata : pool_base_ff;
      cmd_in        = cmd_ff;
      va_in         = va_ff;
      pa_ppn_in     = pa_ppn_ff;
      count_in      = count_ff;
      perm_in       = perm_ff;
      level_in      = level_ff;
      page_in       = page_ff;
      alloc_page_in = alloc_page_ff;
      next_free_in  = next_free_ff;
      clr_addr_in   = clr_addr_ff;
      stat_in       = stat_ff;
      res_addr_in   = res_addr_ff;
      rsp_status_in = rsp_status_ff;
      rsp_addr_in   = rsp_addr_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_tready;
      mem_we        = 1'b0;
      mem_waddr     = clr_addr_ff;
      mem_wdata     = '0;

      case (state_ff)
         sv39pt_pkg::ST_INIT: begin
            mem_we      = 1'b1;
            clr_addr_in = clr_addr_ff + sv39pt_pkg::ADDR_W'(1);
         end
         sv39pt_pkg::ST_IDLE: begin
            if (req_fire) begin
               cmd_in      = req_tuser[0];
               va_in       = req_tdata[63:0];
               pa_ppn_in   = req_tdata[119:76];
               count_in    = req_tdata[135:120];
               perm_in     = req_tdata[143:136];
               stat_in     = sv39pt_pkg::STAT_OK;
               res_addr_in = '0;
            end
         end
         sv39pt_pkg::ST_CHECK: begin
            if (is_map && bad_align) begin
               stat_in = sv39pt_pkg::STAT_ALIGN;
            end else if (is_map && (count_ff == '0)) begin
               stat_in = sv39pt_pkg::STAT_ZERO;
            end
         end
         sv39pt_pkg::ST_PAGE: begin
            if (bad_range) stat_in = sv39pt_pkg::STAT_RANGE;
            page_in  = '0;
            level_in = 2'd2;
         end
         sv39pt_pkg::ST_EVAL: begin
            if (level_ff != 2'd0) begin
               if (mem_rdata[sv39pt_pkg::FLAG_V]) begin
                  if (ptr_info.in_pool) begin
                     page_in  = ptr_info.page;
                     level_in = level_ff - 2'd1;
                  end else begin
                     stat_in = sv39pt_pkg::STAT_RANGE;
                  end
               end else if (!is_map) begin
                  stat_in = sv39pt_pkg::STAT_RANGE;
               end else if (pool_full) begin
                  stat_in = sv39pt_pkg::STAT_POOL;
               end else begin
                  alloc_page_in = next_free_ff[sv39pt_pkg::PAGE_W-1:0];
                  next_free_in  = next_free_ff + sv39pt_pkg::NFP_W'(1);
                  clr_addr_in   = {next_free_ff[sv39pt_pkg::PAGE_W-1:0],
                                   {sv39pt_pkg::IDX_W{1'b0}}};
               end
            end else if (!is_map) begin
               if (mem_rdata[sv39pt_pkg::FLAG_V] && mem_rdata[sv39pt_pkg::FLAG_U]) begin
                  res_addr_in = entry_pa;
               end else begin
                  stat_in = sv39pt_pkg::STAT_RANGE;
               end
            end else if (mem_rdata[sv39pt_pkg::FLAG_V]) begin
               stat_in = sv39pt_pkg::STAT_REMAP;
            end else begin
               mem_we    = 1'b1;
               mem_waddr = mem_raddr;
               mem_wdata = leaf_entry;
               va_in     = va_ff + sv39pt_pkg::VA_W'(4096);
               pa_ppn_in = pa_ppn_ff + sv39pt_pkg::PPN_W'(1);
               count_in  = count_ff - sv39pt_pkg::CNT_W'(1);
            end
         end
         sv39pt_pkg::ST_CLEAR: begin
            mem_we      = 1'b1;
            clr_addr_in = clr_addr_ff + sv39pt_pkg::ADDR_W'(1);
         end
         sv39pt_pkg::ST_LINK: begin
            // The new page is cleared first; the pointer is then written into the current page.
            mem_we    = 1'b1;
            mem_waddr = mem_raddr;
            mem_wdata = link_entry;
            page_in   = alloc_page_ff;
            level_in  = level_ff - 2'd1;
         end
         sv39pt_pkg::ST_DONE: begin
            if (slot_free) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = stat_ff;
               rsp_addr_in   = res_addr_ff;
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= sv39pt_pkg::ST_INIT;
         pool_base_ff <= '0;
         next_free_ff <= sv39pt_pkg::NFP_W'(1);
         clr_addr_ff  <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         pool_base_ff <= pool_base_in;
         next_free_ff <= next_free_in;
         clr_addr_ff  <= clr_addr_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff        <= cmd_in;
      va_ff         <= va_in;
      pa_ppn_ff     <= pa_ppn_in;
      count_ff      <= count_in;
      perm_ff       <= perm_in;
      level_ff      <= level_in;
      page_ff       <= page_in;
      alloc_page_ff <= alloc_page_in;
      stat_ff       <= stat_in;
      res_addr_ff   <= res_addr_in;
      rsp_status_ff <= rsp_status_in;
      rsp_addr_ff   <= rsp_addr_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {5'b00000, rsp_addr_ff, rsp_status_ff};

   // The pool hands out pages one at a time and never past its end.
   assert property (@(posedge clock) disable iff (reset)
      next_free_ff <= sv39pt_pkg::NFP_W'(sv39pt_pkg::POOL_PAGES))
      else $error("free page pointer ran past the pool");

   assert property (@(posedge clock) disable iff (reset)
      ($past(!reset) && (next_free_ff != $past(next_free_ff)))
      |-> (next_free_ff == $past(next_free_ff) + sv39pt_pkg::NFP_W'(1)))
      else $error("free page pointer moved by other than one page");

   // The table is never written while the sequencer is parked.
   assert property (@(posedge clock) disable iff (reset)
      mem_we |-> ((state_ff != sv39pt_pkg::ST_IDLE) && (state_ff != sv39pt_pkg::ST_DONE)))
      else $error("table write outside a walk or clear");

   // A response word appears only when a request has just finished.
   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> ($past(state_ff) == sv39pt_pkg::ST_DONE))
      else $error("response raised outside completion");

endmodule
